// ===== src/ceha_pkg.sv =====
package ceha_pkg;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_DEPOSIT = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;
    localparam logic [1:0] CMD_SPARE   = 2'd3;

    localparam logic [2:0] ST_IGNORED    = 3'd0;
    localparam logic [2:0] ST_ACCUM      = 3'd1;
    localparam logic [2:0] ST_NEW_ENTRY  = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_READ_OK    = 3'd4;
    localparam logic [2:0] ST_READ_EMPTY = 3'd5;
    localparam logic [2:0] ST_CLEARED    = 3'd6;

    localparam int unsigned E_W = 40;

    typedef struct packed {
        logic [1:0]         command;
        logic [19:0]        cell_id;
        logic [23:0]        energy;
        logic               is_em;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        hit_time;
        logic [7:0]         read_index;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         entry_index;
        logic [19:0]        entry_cell;
        logic [E_W-1:0]     total_energy;
        logic [E_W-1:0]     em_energy;
        logic [E_W-1:0]     nonem_energy;
        logic signed [31:0] entry_x;
        logic signed [31:0] entry_y;
        logic signed [31:0] entry_z;
        logic [31:0]        first_time;
        logic [8:0]         entry_count;
    } t_res;

    // request in flight along the cell row
    typedef struct packed {
        t_req req;
        logic done;
        t_res res;
    } t_tok;

    function automatic logic [E_W-1:0] sat_add(logic [E_W-1:0] a, logic [23:0] b);
        logic [E_W:0] s;
        s = {1'b0, a} + (E_W + 1)'(b);
        return s[E_W] ? '1 : s[E_W-1:0];
    endfunction

endpackage

// ===== src/ceha_chan_if.sv =====
interface ceha_chan_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/ceha_cell.sv =====
module ceha_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned IX_W  = 8,
    parameter int unsigned CNT_W = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_tok_valid,
    input  ceha_pkg::t_tok      i_tok,
    input  logic [CNT_W-1:0]    i_count,
    output logic                o_tok_valid,
    output ceha_pkg::t_tok      o_tok,
    output logic [CNT_W-1:0]    o_count
);
    import ceha_pkg::*;

    localparam int unsigned CMP_W = (IX_W > 8) ? IX_W : 8;

    logic                r_valid, n_valid;
    logic [19:0]         r_cell, n_cell;
    logic [E_W-1:0]      r_total, n_total;
    logic [E_W-1:0]      r_em, n_em;
    logic [E_W-1:0]      r_nonem, n_nonem;
    logic signed [31:0]  r_x, n_x;
    logic signed [31:0]  r_y, n_y;
    logic signed [31:0]  r_z, n_z;
    logic [31:0]         r_time, n_time;
    t_tok                n_tok;
    logic                hit;
    logic                ix_match;

    assign hit      = r_valid && (r_cell == i_tok.req.cell_id);
    assign ix_match = (CMP_W'(i_tok.req.read_index) == CMP_W'(INDEX));

    always_comb begin
        n_valid = r_valid;
        n_cell  = r_cell;
        n_total = r_total;
        n_em    = r_em;
        n_nonem = r_nonem;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_time  = r_time;
        n_tok   = i_tok;
        if (i_tok_valid) begin
            case (i_tok.req.command)
                CMD_CLEAR: begin
                    n_valid = 1'b0;
                end
                CMD_DEPOSIT: begin
                    if (!i_tok.done && hit) begin
                        n_total = sat_add(r_total, i_tok.req.energy);
                        if (i_tok.req.is_em) begin
                            n_em = sat_add(r_em, i_tok.req.energy);
                        end else begin
                            n_nonem = sat_add(r_nonem, i_tok.req.energy);
                        end
                        n_tok.done       = 1'b1;
                        n_tok.res.status = ST_ACCUM;
                    end else if (!i_tok.done && !r_valid) begin
                        n_valid = 1'b1;
                        n_cell  = i_tok.req.cell_id;
                        n_total = E_W'(i_tok.req.energy);
                        n_em    = i_tok.req.is_em ? E_W'(i_tok.req.energy) : '0;
                        n_nonem = i_tok.req.is_em ? '0 : E_W'(i_tok.req.energy);
                        n_x     = i_tok.req.pos_x;
                        n_y     = i_tok.req.pos_y;
                        n_z     = i_tok.req.pos_z;
                        n_time  = i_tok.req.hit_time;
                        n_tok.done       = 1'b1;
                        n_tok.res.status = ST_NEW_ENTRY;
                    end
                end
                CMD_READ: begin
                    if (!i_tok.done && ix_match) begin
                        n_tok.done = 1'b1;
                        if (r_valid) begin
                            n_tok.res.status = ST_READ_OK;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (n_tok.done && !i_tok.done && n_tok.res.status != ST_READ_EMPTY) begin
                n_tok.res.entry_index  = 8'(INDEX);
                n_tok.res.entry_cell   = n_cell;
                n_tok.res.total_energy = n_total;
                n_tok.res.em_energy    = n_em;
                n_tok.res.nonem_energy = n_nonem;
                n_tok.res.entry_x      = n_x;
                n_tok.res.entry_y      = n_y;
                n_tok.res.entry_z      = n_z;
                n_tok.res.first_time   = n_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            o_tok_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid     <= n_valid;
            o_tok_valid <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cell  <= n_cell;
            r_total <= n_total;
            r_em    <= n_em;
            r_nonem <= n_nonem;
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_time  <= n_time;
            o_tok   <= n_tok;
            o_count <= i_count + CNT_W'(n_valid);
        end
    end

endmodule

// ===== src/cell_energy_hit_accumulator.sv =====
// Calorimeter cell hit table, one entry per struck cell id.
// i_req (sink): one request per handshake; command clear, deposit or read,
//   with cell id, energy, em flag, position, time and read index.
// o_res (source): exactly one result per request, in request order: status,
//   the slot touched or read with its sums, position and first time, and the
//   number of valid entries after the request.
// The table is a row of TABLE_DEPTH cells, one entry per cell. A request
// walks the row one cell per cycle while the row is not held; the matching
// cell accumulates, the first empty cell takes a new id, and each cell adds
// its valid bit to the count. Each cell registers the request as it passes,
// and a new request is taken every cycle while the row is not held.
// The last cell's register is the output register. While o_res.valid is high
// and o_res.ready is low the whole row holds and i_req.ready is low.
// Reset empties the table and drops all requests in flight.
module cell_energy_hit_accumulator #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ceha_chan_if.sink   i_req,
    ceha_chan_if.source o_res
);
    import ceha_pkg::*;

    localparam int unsigned IX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    logic             adv;
    logic             w_val [TABLE_DEPTH+1];
    t_tok             w_tok [TABLE_DEPTH+1];
    logic [CNT_W-1:0] w_cnt [TABLE_DEPTH+1];
    t_tok             tok_in;
    t_req             req;

    assign req = i_req.payload;
    assign adv = !w_val[TABLE_DEPTH] || o_res.ready;
    assign i_req.ready = adv;

    always_comb begin
        tok_in      = '0;
        tok_in.req  = req;
        tok_in.done = 1'b1;
        case (req.command)
            CMD_CLEAR: begin
                tok_in.res.status = ST_CLEARED;
            end
            CMD_DEPOSIT: begin
                if (req.energy == '0) begin
                    tok_in.res.status = ST_IGNORED;
                end else begin
                    tok_in.res.status = ST_FULL;
                    tok_in.done       = 1'b0;
                end
            end
            CMD_READ: begin
                tok_in.res.status      = ST_READ_EMPTY;
                tok_in.res.entry_index = req.read_index;
                tok_in.done            = 1'b0;
            end
            default: begin
                tok_in.res.status = ST_IGNORED;
            end
        endcase
    end

    assign w_val[0] = i_req.valid;
    assign w_tok[0] = tok_in;
    assign w_cnt[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        ceha_cell #(
            .INDEX (g),
            .IX_W  (IX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_adv       (adv),
            .i_tok_valid (w_val[g]),
            .i_tok       (w_tok[g]),
            .i_count     (w_cnt[g]),
            .o_tok_valid (w_val[g+1]),
            .o_tok       (w_tok[g+1]),
            .o_count     (w_cnt[g+1])
        );
    end

    always_comb begin
        o_res.payload             = w_tok[TABLE_DEPTH].res;
        o_res.payload.entry_count = 9'(w_cnt[TABLE_DEPTH]);
    end
    assign o_res.valid = w_val[TABLE_DEPTH];

    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.payload.status == ST_CLEARED |->
            o_res.payload.entry_count == 9'd0)
        else $error("clear result with nonzero entry count");

    a_new_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.payload.status == ST_NEW_ENTRY |->
            o_res.payload.entry_index == 8'(o_res.payload.entry_count - 9'd1))
        else $error("new entry not at end of table");

    a_ignored_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.payload.status == ST_IGNORED |->
            o_res.payload.total_energy == '0 && o_res.payload.entry_index == 8'd0)
        else $error("ignored request carries slot data");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

endmodule
